FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the instruction executor.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_NEVER(lbl, clk, rst_n, expr, msg)
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/mse_pkg.sv
// Shared types and constants of the MIPS subset executor.
// Depends on nothing; used by every module of the block.
package mse_pkg;

    localparam logic [5:0] OPC_REGIMM = 6'd1;
    localparam logic [5:0] OPC_J      = 6'd2;
    localparam logic [5:0] OPC_JAL    = 6'd3;
    localparam logic [5:0] OPC_BEQ    = 6'd4;
    localparam logic [5:0] OPC_BNE    = 6'd5;
    localparam logic [5:0] OPC_ADDI   = 6'd8;
    localparam logic [5:0] OPC_SLTI   = 6'd10;
    localparam logic [5:0] OPC_ANDI   = 6'd12;
    localparam logic [5:0] OPC_ORI    = 6'd13;
    localparam logic [5:0] OPC_XORI   = 6'd14;
    localparam logic [5:0] OPC_LUI    = 6'd15;
    localparam logic [5:0] OPC_LB     = 6'd32;
    localparam logic [5:0] OPC_LW     = 6'd35;
    localparam logic [5:0] OPC_LBU    = 6'd36;
    localparam logic [5:0] OPC_SB     = 6'd40;
    localparam logic [5:0] OPC_SW     = 6'd43;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MUL     = 6'd24;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;

    localparam logic [11:0] SEL_DATA    = 12'h100;
    localparam logic [11:0] SEL_STACK   = 12'h7FF;
    localparam logic [31:0] EXIT_CODE   = 32'd10;
    localparam logic [31:0] START_RESET = 32'h0040_0000;
    localparam logic [4:0]  REG_V0      = 5'd2;
    localparam logic [4:0]  REG_RA      = 5'd31;
    localparam int          REG_COUNT   = 32;

    localparam int               CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAKPOINT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP, OP_BLTZ, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI,
        OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LBU, OP_LW, OP_SB, OP_SW,
        OP_SLL, OP_SRL, OP_SRA, OP_JR, OP_SYSCALL, OP_MUL, OP_ADD, OP_SUB,
        OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic [4:0]  shamt;
        logic [15:0] imm;
        logic [25:0] target;
    } t_decoded;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/mse_front.sv
// Front end: accepts instruction requests and decodes them into operations.
// Depends on mse_pkg.
module mse_front (
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [31:0]         i_instruction,
    input  mse_pkg::t_q_status  i_q_status,
    input  logic                i_busy,
    output logic                o_push,
    output mse_pkg::t_decoded   o_item
);
    import mse_pkg::*;

    logic [5:0] opc;
    logic [5:0] fn;

    assign o_in_stall = i_q_status.full || i_busy;
    assign o_push     = i_in_valid && !o_in_stall;
    assign opc        = i_instruction[31:26];
    assign fn         = i_instruction[5:0];

    always_comb begin
        o_item.rs     = i_instruction[25:21];
        o_item.rt     = i_instruction[20:16];
        o_item.dest   = i_instruction[20:16];
        o_item.shamt  = i_instruction[10:6];
        o_item.imm    = i_instruction[15:0];
        o_item.target = i_instruction[25:0];
        o_item.op     = OP_NOP;
        case (opc)
            OPC_REGIMM: o_item.op = OP_BLTZ;
            OPC_J:      o_item.op = OP_J;
            OPC_JAL: begin
                o_item.op   = OP_JAL;
                o_item.dest = REG_RA;
            end
            OPC_BEQ:    o_item.op = OP_BEQ;
            OPC_BNE:    o_item.op = OP_BNE;
            OPC_ADDI:   o_item.op = OP_ADDI;
            OPC_SLTI:   o_item.op = OP_SLTI;
            OPC_ANDI:   o_item.op = OP_ANDI;
            OPC_ORI:    o_item.op = OP_ORI;
            OPC_XORI:   o_item.op = OP_XORI;
            OPC_LUI:    o_item.op = OP_LUI;
            OPC_LB:     o_item.op = OP_LB;
            OPC_LBU:    o_item.op = OP_LBU;
            OPC_LW:     o_item.op = OP_LW;
            OPC_SB:     o_item.op = OP_SB;
            OPC_SW:     o_item.op = OP_SW;
            default: begin
                // Every other opcode is taken apart by its function field.
                o_item.dest = i_instruction[15:11];
                case (fn)
                    FN_SLL:     o_item.op = OP_SLL;
                    FN_SRL:     o_item.op = OP_SRL;
                    FN_SRA:     o_item.op = OP_SRA;
                    FN_JR:      o_item.op = OP_JR;
                    FN_SYSCALL: o_item.op = OP_SYSCALL;
                    FN_MUL:     o_item.op = OP_MUL;
                    FN_ADD:     o_item.op = OP_ADD;
                    FN_SUB:     o_item.op = OP_SUB;
                    FN_AND:     o_item.op = OP_AND;
                    FN_OR:      o_item.op = OP_OR;
                    FN_XOR:     o_item.op = OP_XOR;
                    FN_NOR:     o_item.op = OP_NOR;
                    FN_SLT:     o_item.op = OP_SLT;
                    default:    o_item.op = OP_NOP;
                endcase
            end
        endcase
    end

endmodule

FILE: rtl/mse_queue.sv
// Two-entry queue of decoded operations between front and back end.
// Depends on mse_pkg.
module mse_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mse_pkg::t_decoded   i_item,
    input  logic                i_pop,
    output mse_pkg::t_decoded   o_item,
    output mse_pkg::t_q_status  o_status
);
    import mse_pkg::*;

    t_decoded   r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_item          = r_buf[r_rp];
    assign o_status.full   = (r_cnt == 2'd2);
    assign o_status.empty  = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_item;
    end

endmodule

FILE: rtl/mse_back.sv
// Back end: register file, data and stack memories, execution and result register.
// Depends on mse_pkg.
module mse_back #(
    parameter int DATA_BYTES  = 4096,
    parameter int STACK_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_q_valid,
    input  mse_pkg::t_decoded             i_q_item,
    output logic                          o_q_pop,
    output logic                          o_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_next_pc,
    output logic                          o_halted,
    output logic                          o_breakpoint_hit,
    output logic                          o_reg_written,
    output logic [4:0]                    o_reg_index,
    output logic [31:0]                   o_reg_value,
    output logic                          o_mem_fault
);
    import mse_pkg::*;

    localparam int DATA_ROWS  = (DATA_BYTES + 3) / 4;
    localparam int STACK_ROWS = (STACK_BYTES + 3) / 4;
    localparam int DROW_W     = $clog2(DATA_ROWS);
    localparam int SROW_W     = $clog2(STACK_ROWS);
    localparam int CLR_ROWS   = (DATA_ROWS > STACK_ROWS) ? DATA_ROWS : STACK_ROWS;
    localparam int CLR_W      = $clog2(CLR_ROWS);
    localparam logic [20:0] D_LIM_B = 21'(DATA_BYTES - 1);
    localparam logic [20:0] D_LIM_W = 21'(DATA_BYTES - 4);
    localparam logic [20:0] S_LIM_B = 21'(STACK_BYTES - 1);
    localparam logic [20:0] S_LIM_W = 21'(STACK_BYTES - 4);

    // Configuration and architectural state.
    logic [31:0] r_bp;
    logic [31:0] r_start;
    logic [31:0] r_pc;
    logic [31:0] r_v0;
    logic [31:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [3:0][7:0] r_dmem [DATA_ROWS];
    logic [3:0][7:0] r_smem [STACK_ROWS];

    // Clearing pass over the memories after reset.
    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_cnt;

    // Execute stage.
    logic        r_ex_valid;
    t_decoded    r_ex;
    logic [31:0] r_a;
    logic [31:0] r_b;

    // Load completion stage.
    logic        r_ld_valid;
    logic        r_ld_stack;
    logic        r_ld_word;
    logic        r_ld_sign;
    logic [1:0]  r_ld_lane;
    logic [4:0]  r_ld_dest;
    logic [31:0] r_ld_next;
    logic [3:0][7:0] r_drd;
    logic [3:0][7:0] r_srd;

    // Result register.
    logic        r_out_valid;
    logic [31:0] r_out_next;
    logic        r_out_halt;
    logic        r_out_bp;
    logic        r_out_wr;
    logic [4:0]  r_out_idx;
    logic [31:0] r_out_val;
    logic        r_out_fault;

    logic        out_free;
    logic        issue;
    logic        ex_done;
    logic        ex_adv_ld;
    logic        ld_done;
    logic [31:0] sext;
    logic [31:0] pc4;
    logic [31:0] branch;
    logic [31:0] jump;
    logic [31:0] addr;
    logic [19:0] off;
    logic        is_load;
    logic        is_store;
    logic        is_word;
    logic        d_hit;
    logic        s_hit;
    logic        mem_ok;
    logic [31:0] ex_next;
    logic        ex_wr;
    logic [31:0] ex_val;
    logic        ex_halt;
    logic        ex_fault;
    logic [3:0][7:0] ld_row;
    logic [31:0] ld_val;
    logic [31:0] fin_next;
    logic        fin_wr;
    logic [4:0]  fin_idx;
    logic [31:0] fin_val;
    logic        fin_halt;
    logic        fin_fault;
    logic        rf_we;
    logic [3:0]  st_be;
    logic [31:0] st_wd;
    logic [3:0]  d_we;
    logic [DROW_W-1:0] d_row;
    logic [31:0] d_wd;
    logic [3:0]  s_we;
    logic [SROW_W-1:0] s_row;
    logic [31:0] s_wd;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = r_clr_busy;

    // Handshake between the stages. A load blocks issue until its data is back.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign ex_adv_ld = r_ex_valid && is_load && mem_ok;
    assign ex_done   = r_ex_valid && !(is_load && mem_ok) && out_free;
    assign ld_done   = r_ld_valid && out_free;
    assign issue     = i_q_valid && !r_clr_busy && (!r_ld_valid || ld_done)
                       && (!r_ex_valid || ex_done);
    assign o_q_pop   = issue;

    // Execute.
    assign sext    = {{16{r_ex.imm[15]}}, r_ex.imm};
    assign pc4     = r_pc + 32'd4;
    assign branch  = pc4 + {sext[29:0], 2'b00};
    assign jump    = {pc4[31:28], r_ex.target, 2'b00};
    assign addr    = r_a + sext;
    assign off     = addr[19:0];
    assign is_load  = (r_ex.op == OP_LB) || (r_ex.op == OP_LBU) || (r_ex.op == OP_LW);
    assign is_store = (r_ex.op == OP_SB) || (r_ex.op == OP_SW);
    assign is_word  = (r_ex.op == OP_LW) || (r_ex.op == OP_SW);
    assign d_hit   = (addr[31:20] == SEL_DATA)
                     && ({1'b0, off} <= (is_word ? D_LIM_W : D_LIM_B));
    assign s_hit   = (addr[31:20] == SEL_STACK)
                     && ({1'b0, off} <= (is_word ? S_LIM_W : S_LIM_B));
    assign mem_ok  = (d_hit || s_hit) && (!is_word || (addr[1:0] == 2'b00));

    always_comb begin
        ex_next  = pc4;
        ex_wr    = 1'b0;
        ex_val   = '0;
        ex_halt  = 1'b0;
        ex_fault = 1'b0;
        case (r_ex.op)
            OP_BLTZ: if (r_a[31]) ex_next = branch;
            OP_J:    ex_next = jump;
            OP_JAL: begin
                ex_next = jump;
                ex_wr   = 1'b1;
                ex_val  = pc4;
            end
            OP_BEQ:  if (r_a == r_b) ex_next = branch;
            OP_BNE:  if (r_a != r_b) ex_next = branch;
            OP_ADDI: begin ex_wr = 1'b1; ex_val = r_a + sext; end
            OP_SLTI: begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(r_a) < $signed(sext)};
            end
            OP_ANDI: begin ex_wr = 1'b1; ex_val = r_a & {16'd0, r_ex.imm}; end
            OP_ORI:  begin ex_wr = 1'b1; ex_val = r_a | {16'd0, r_ex.imm}; end
            OP_XORI: begin ex_wr = 1'b1; ex_val = r_a ^ {16'd0, r_ex.imm}; end
            OP_LUI:  begin ex_wr = 1'b1; ex_val = {r_ex.imm, 16'd0}; end
            OP_LB, OP_LBU, OP_LW, OP_SB, OP_SW: ex_fault = !mem_ok;
            OP_SLL:  begin ex_wr = 1'b1; ex_val = r_b << r_ex.shamt; end
            OP_SRL:  begin ex_wr = 1'b1; ex_val = r_b >> r_ex.shamt; end
            OP_SRA:  begin ex_wr = 1'b1; ex_val = $unsigned($signed(r_b) >>> r_ex.shamt); end
            OP_JR:   ex_next = r_a;
            OP_SYSCALL: begin
                if (r_v0 == EXIT_CODE) begin
                    ex_halt = 1'b1;
                    ex_next = r_start;
                end
            end
            OP_MUL:  begin ex_wr = 1'b1; ex_val = r_a * r_b; end
            OP_ADD:  begin ex_wr = 1'b1; ex_val = r_a + r_b; end
            OP_SUB:  begin ex_wr = 1'b1; ex_val = r_a - r_b; end
            OP_AND:  begin ex_wr = 1'b1; ex_val = r_a & r_b; end
            OP_OR:   begin ex_wr = 1'b1; ex_val = r_a | r_b; end
            OP_XOR:  begin ex_wr = 1'b1; ex_val = r_a ^ r_b; end
            OP_NOR:  begin ex_wr = 1'b1; ex_val = ~(r_a | r_b); end
            OP_SLT:  begin
                ex_wr  = 1'b1;
                ex_val = {31'd0, $signed(r_a) < $signed(r_b)};
            end
            default: ex_next = pc4;
        endcase
    end

    // Load completion: big-endian, byte offset zero sits in the top lane.
    assign ld_row = r_ld_stack ? r_srd : r_drd;
    always_comb begin
        if (r_ld_word) begin
            ld_val = ld_row;
        end else if (r_ld_sign) begin
            ld_val = {{24{ld_row[r_ld_lane][7]}}, ld_row[r_ld_lane]};
        end else begin
            ld_val = {24'd0, ld_row[r_ld_lane]};
        end
    end

    // Retirement; writes to r0 vanish together with their value.
    always_comb begin
        if (ld_done) begin
            fin_next  = r_ld_next;
            fin_wr    = (r_ld_dest != 5'd0);
            fin_val   = ld_val;
            fin_halt  = 1'b0;
            fin_fault = 1'b0;
            fin_idx   = r_ld_dest;
        end else begin
            fin_next  = ex_next;
            fin_wr    = ex_wr && (r_ex.dest != 5'd0);
            fin_val   = ex_val;
            fin_halt  = ex_halt;
            fin_fault = ex_fault;
            fin_idx   = r_ex.dest;
        end
        if (!fin_wr) begin
            fin_idx = 5'd0;
            fin_val = '0;
        end
    end

    assign rf_we = (ex_done || ld_done) && fin_wr;

    // Memory write ports: the clearing pass first, then stores.
    assign st_be = is_word ? 4'b1111 : (4'b0001 << (~off[1:0]));
    assign st_wd = is_word ? r_b : {4{r_b[7:0]}};

    always_comb begin
        d_we  = 4'b0000;
        d_row = off[DROW_W+1:2];
        d_wd  = st_wd;
        s_we  = 4'b0000;
        s_row = off[SROW_W+1:2];
        s_wd  = st_wd;
        if (r_clr_busy) begin
            d_row = r_clr_cnt[DROW_W-1:0];
            s_row = r_clr_cnt[SROW_W-1:0];
            d_wd  = '0;
            s_wd  = '0;
            if ({1'b0, r_clr_cnt} < (CLR_W+1)'(DATA_ROWS))  d_we = 4'b1111;
            if ({1'b0, r_clr_cnt} < (CLR_W+1)'(STACK_ROWS)) s_we = 4'b1111;
        end else if (ex_done && is_store && mem_ok) begin
            if (d_hit) d_we = st_be;
            else       s_we = st_be;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            if (d_we[l]) r_dmem[d_row][l] <= d_wd[8*l +: 8];
            if (s_we[l]) r_smem[s_row][l] <= s_wd[8*l +: 8];
        end
        r_drd <= r_dmem[off[DROW_W+1:2]];
        r_srd <= r_smem[off[SROW_W+1:2]];
    end

    // Register file with write-first read for an operand retired in the same cycle.
    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[fin_idx] <= fin_val;
        if (issue) begin
            if (rf_we && (fin_idx == i_q_item.rs)) r_a <= fin_val;
            else r_a <= r_rf_vld[i_q_item.rs] ? r_rf[i_q_item.rs] : '0;
            if (rf_we && (fin_idx == i_q_item.rt)) r_b <= fin_val;
            else r_b <= r_rf_vld[i_q_item.rt] ? r_rf[i_q_item.rt] : '0;
            r_ex <= i_q_item;
        end
        if (ex_adv_ld) begin
            r_ld_stack <= s_hit && !d_hit;
            r_ld_word  <= is_word;
            r_ld_sign  <= (r_ex.op == OP_LB);
            r_ld_lane  <= ~off[1:0];
            r_ld_dest  <= r_ex.dest;
            r_ld_next  <= pc4;
        end
        if (ex_done || ld_done) begin
            r_out_next  <= fin_next;
            r_out_halt  <= fin_halt;
            r_out_bp    <= (fin_next == r_bp);
            r_out_wr    <= fin_wr;
            r_out_idx   <= fin_idx;
            r_out_val   <= fin_val;
            r_out_fault <= fin_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp        <= '0;
            r_start     <= START_RESET;
            r_pc        <= START_RESET;
            r_v0        <= '0;
            r_rf_vld    <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_ex_valid  <= 1'b0;
            r_ld_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BREAKPOINT) r_bp <= i_cfg_data;
                if (i_cfg_index == CFG_START)      r_start <= i_cfg_data;
            end
            if (r_clr_busy) begin
                if (r_clr_cnt == CLR_W'(CLR_ROWS - 1)) r_clr_busy <= 1'b0;
                else r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            if (rf_we) begin
                r_rf_vld[fin_idx] <= 1'b1;
                if (fin_idx == REG_V0) r_v0 <= fin_val;
            end
            if (ex_done || ld_done) r_pc <= fin_next;
            if (issue) r_ex_valid <= 1'b1;
            else if (ex_done || ex_adv_ld) r_ex_valid <= 1'b0;
            if (ex_adv_ld) r_ld_valid <= 1'b1;
            else if (ld_done) r_ld_valid <= 1'b0;
            if (ex_done || ld_done) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_next_pc        = r_out_next;
    assign o_halted         = r_out_halt;
    assign o_breakpoint_hit = r_out_bp;
    assign o_reg_written    = r_out_wr;
    assign o_reg_index      = r_out_idx;
    assign o_reg_value      = r_out_val;
    assign o_mem_fault      = r_out_fault;

endmodule

FILE: rtl/mips_subset_instruction_executor.sv
// Top level of the MIPS subset instruction executor.
// Depends on mse_pkg, mse_front, mse_queue, mse_back and assert_macros.svh.
//
//  Channel   Direction  Handshake                 Payload
//  in        request in i_in_valid / o_in_stall   i_instruction
//  out       result out o_out_valid / i_out_stall o_next_pc .. o_mem_fault
//  cfg       write in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each request is decoded in the front end and queued (two entries) for the back end.
// Sustained: one instruction per cycle while no result is stalled; a load holds
// back the next one, since the memory read is registered and the next instruction
// waits for its register write. An accepted request passes the queue, the execute
// registers and the result register; a load also passes the load completion
// registers. After reset the memories are cleared one four-byte row per cycle;
// o_in_stall is high throughout, whereas configuration writes are taken at any time.
// A stalled result holds the back end while the queue keeps taking requests.
`include "assert_macros.svh"

module mips_subset_instruction_executor #(
    parameter int DATA_BYTES  = 4096,
    parameter int STACK_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_instruction,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_next_pc,
    output logic                          o_halted,
    output logic                          o_breakpoint_hit,
    output logic                          o_reg_written,
    output logic [4:0]                    o_reg_index,
    output logic [31:0]                   o_reg_value,
    output logic                          o_mem_fault,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import mse_pkg::*;

    t_q_status q_status;
    t_decoded  push_item;
    t_decoded  head_item;
    logic      push;
    logic      pop;
    logic      busy;

    // The front end decodes each request as it is accepted.
    mse_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_instruction (i_instruction),
        .i_q_status    (q_status),
        .i_busy        (busy),
        .o_push        (push),
        .o_item        (push_item)
    );

    // The queue lets the front keep accepting while a result is stalled.
    mse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // The back end holds all architectural state and produces the results.
    mse_back #(
        .DATA_BYTES  (DATA_BYTES),
        .STACK_BYTES (STACK_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_q_valid        (!q_status.empty),
        .i_q_item         (head_item),
        .o_q_pop          (pop),
        .o_busy           (busy),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_next_pc        (o_next_pc),
        .o_halted         (o_halted),
        .o_breakpoint_hit (o_breakpoint_hit),
        .o_reg_written    (o_reg_written),
        .o_reg_index      (o_reg_index),
        .o_reg_value      (o_reg_value),
        .o_mem_fault      (o_mem_fault)
    );

    `CHK_NEVER(a_no_accept_while_clearing, i_clk, i_rst_n, push && busy, "request taken during clearing pass")
    `CHK_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, pop && q_status.empty, "queue popped while empty")
    `CHK_IMPLY(a_fault_no_write, i_clk, i_rst_n, o_out_valid && o_mem_fault, !o_reg_written, "faulting access wrote a register")
    `CHK_IMPLY(a_r0_untouched, i_clk, i_rst_n, o_out_valid && o_reg_written, o_reg_index != 5'd0, "write to r0 reported")

endmodule
